FILE: rtl/swts_pkg.sv
// ----------------------------------------------------------------------------
// swts_pkg
// Shared widths, defaults, tdata field offsets and the control/status
// bundles between the sequencer and the datapath of the shortest-window block.
// ----------------------------------------------------------------------------
package swts_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int VALUE_W     = 16;
  localparam int POS_OUT_W   = 20;
  localparam int TARGET_W    = 32;
  localparam int SUM_W       = TARGET_W + 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  // Output tdata field offsets, lowest bit first
  localparam int OUT_START_LSB = 0;
  localparam int OUT_END_LSB   = OUT_START_LSB + POS_OUT_W;
  localparam int OUT_FOUND_BIT = OUT_END_LSB + POS_OUT_W;
  localparam int OUT_OVF_BIT   = OUT_FOUND_BIT + 1;

  // Parameter defaults
  localparam int WINDOW_DEPTH_DEF  = 4096;
  localparam int POSITION_BITS_DEF = 20;
  localparam int VALUE_BITS_DEF    = 16;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;      // take the request, restart the stream if flagged
    logic append;    // write the value at the tail and add it to the sum
    logic mem_rd;    // read the front entry of the window
    logic drop;      // subtract the front entry and advance the head
    logic ovf_set;   // mark the store as overrun
    logic best_upd;  // take the current window as the best run
    logic finish;    // advance the position and load the result register
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic full;      // window store holds its maximum
    logic nonempty;  // window holds at least one value
    logic gt;        // running sum above target
    logic eq;        // running sum equals target
    logic better;    // current window beats the best run
    logic out_free;  // result register can take a new result
  } status_t;

endpackage

FILE: rtl/shortest_window_with_target_sum.sv
// Sequence: take the request, append the value (dropping the oldest first if
//   the store is full), trim front values while the sum is above target, drop
//   the front after a match, then load the result register once it is free.
// Flow: one request at a time; over a stream, every value is dropped at most once.
// Reset: asynchronous, active low; clears the window, sums, positions, flags
//   and target. The window store itself is not cleared.
// ----------------------------------------------------------------------------
// shortest_window_with_target_sum
// Streams unsigned values, keeps a sliding window whose sum never exceeds the
// target and reports the shortest run so far that sums exactly to the target.
// ----------------------------------------------------------------------------
module shortest_window_with_target_sum #(
  parameter int WINDOW_DEPTH  = swts_pkg::WINDOW_DEPTH_DEF,
  parameter int POSITION_BITS = swts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = swts_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration: target sum
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swts_pkg::TARGET_W-1:0]    cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [swts_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [15:0] value
  input  logic                             s_axis_tuser_i,  // [0] first
  // result stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [19:0] best_start, [39:20] best_end, [40] found, [41] overflow, [47:42] 0
  output logic [swts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  swts_pkg::cmd_t    cmd;
  swts_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  swts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  swts_dpath #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .POSITION_BITS (POSITION_BITS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (s_axis_tdata_i[swts_pkg::VALUE_W-1:0]),
    .first_i     (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

FILE: rtl/swts_ctrl.sv
// ----------------------------------------------------------------------------
// swts_ctrl
// Sequencer: walks each request through append, front-drop loop, match
// check and result hand-off, issuing one command set per cycle.
// ----------------------------------------------------------------------------
module swts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  swts_pkg::status_t status_i,
  output swts_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_APPEND = 7'b0000010,
    ST_FULL   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_DROP   = 7'b0010000,
    ST_MDROP  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign s_ready_o = (state_q == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_APPEND;
        end
      end
      ST_APPEND: begin
        if (status_i.full) begin
          // make room: fetch the oldest value first
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_FULL;
        end else begin
          cmd_o.append = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_FULL: begin
        cmd_o.drop    = 1'b1;
        cmd_o.ovf_set = 1'b1;
        state_d       = ST_APPEND;
      end
      ST_SCAN: begin
        priority if (status_i.gt && status_i.nonempty) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = ST_DROP;
        end else if (status_i.eq && status_i.nonempty) begin
          cmd_o.best_upd = status_i.better;
          cmd_o.mem_rd   = 1'b1;
          state_d        = ST_MDROP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_DROP: begin
        cmd_o.drop = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_MDROP: begin
        cmd_o.drop = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the result register frees up
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/swts_dpath.sv
// ----------------------------------------------------------------------------
// swts_dpath
// Datapath: window store, head/count pointers, running sum, positions,
// best run, flags, target register and the output result register.
// ----------------------------------------------------------------------------
module swts_dpath #(
  parameter int WINDOW_DEPTH  = swts_pkg::WINDOW_DEPTH_DEF,
  parameter int POSITION_BITS = swts_pkg::POSITION_BITS_DEF,
  parameter int VALUE_BITS    = swts_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [swts_pkg::TARGET_W-1:0]    cfg_data_i,
  input  logic [swts_pkg::VALUE_W-1:0]     value_i,
  input  logic                             first_i,
  input  swts_pkg::cmd_t                   cmd_i,
  output swts_pkg::status_t                status_o,
  input  logic                             m_ready_i,
  output logic                             m_valid_o,
  output logic [swts_pkg::OUT_TDATA_W-1:0] m_data_o
);

  localparam int AW    = $clog2(WINDOW_DEPTH);
  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int TW    = AW + 1;
  localparam int PW    = POSITION_BITS;
  localparam int VB    = VALUE_BITS;
  localparam int SW    = swts_pkg::SUM_W;
  localparam int OW    = swts_pkg::POS_OUT_W;

  logic [swts_pkg::TARGET_W-1:0] target_q;
  logic [VB-1:0]                 value_q;
  logic [VB-1:0]                 rd_data_q;
  logic [VB-1:0]                 mem_q [WINDOW_DEPTH];

  logic [AW-1:0] head_q, head_d, head_inc, tail;
  logic [TW-1:0] tail_sum;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] sum_q, sum_d, target_ext;
  logic [PW-1:0] pos_q, pos_d, pos_inc;
  logic [PW-1:0] start_q, start_d;
  logic [PW-1:0] bfirst_q, bfirst_d;
  logic [PW-1:0] blast_q, blast_d;
  logic          found_q, found_d;
  logic          ovf_q, ovf_d, ovf_new;

  logic                             out_valid_q, out_valid_d;
  logic [swts_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Target register, to be written only between requests; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_valid_i) begin
      target_q <= cfg_data_i;
    end
  end

  // Capture the incoming value
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= VB'(value_i);
    end
  end

  // Pointer arithmetic, wrapping at the store depth
  assign head_inc = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum = TW'(head_q) + TW'(count_q);
  assign tail     = (tail_sum >= TW'(WINDOW_DEPTH)) ?
                    AW'(tail_sum - TW'(WINDOW_DEPTH)) : AW'(tail_sum);

  // Window store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      mem_q[tail] <= value_q;
    end
    if (cmd_i.mem_rd) begin
      rd_data_q <= mem_q[head_q];
    end
  end

  assign pos_inc    = pos_q + 1'b1;
  assign target_ext = SW'(target_q);
  assign ovf_new    = ovf_q | (pos_inc == '0);

  // Stream state update
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    sum_d    = sum_q;
    pos_d    = pos_q;
    start_d  = start_q;
    bfirst_d = bfirst_q;
    blast_d  = blast_q;
    found_d  = found_q;
    ovf_d    = ovf_q;
    if (cmd_i.load && first_i) begin
      head_d   = '0;
      count_d  = '0;
      sum_d    = '0;
      pos_d    = '0;
      start_d  = '0;
      bfirst_d = '0;
      blast_d  = '0;
      found_d  = 1'b0;
      ovf_d    = 1'b0;
    end
    if (cmd_i.drop) begin
      sum_d   = sum_q - SW'(rd_data_q);
      head_d  = head_inc;
      count_d = count_q - 1'b1;
      start_d = start_q + 1'b1;
    end
    if (cmd_i.ovf_set) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.append) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + SW'(value_q);
    end
    if (cmd_i.best_upd) begin
      bfirst_d = start_q;
      blast_d  = pos_q;
      found_d  = 1'b1;
    end
    if (cmd_i.finish) begin
      pos_d = pos_inc;
      ovf_d = ovf_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      sum_q    <= '0;
      pos_q    <= '0;
      start_q  <= '0;
      bfirst_q <= '0;
      blast_q  <= '0;
      found_q  <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      bfirst_q <= bfirst_d;
      blast_q  <= blast_d;
      found_q  <= found_d;
      ovf_q    <= ovf_d;
    end
  end

  // Status toward the sequencer
  assign status_o.full     = (count_q == CW'(WINDOW_DEPTH));
  assign status_o.nonempty = (count_q != '0);
  assign status_o.gt       = (sum_q > target_ext);
  assign status_o.eq       = (sum_q == target_ext);
  assign status_o.better   = !found_q || ((blast_q - bfirst_q) > (pos_q - start_q));
  assign status_o.out_free = !out_valid_q || m_ready_i;

  // Result register
  always_comb begin
    out_data_d = '0;
    out_data_d[swts_pkg::OUT_START_LSB +: OW] = OW'(bfirst_q);
    out_data_d[swts_pkg::OUT_END_LSB +: OW]   = OW'(blast_q);
    out_data_d[swts_pkg::OUT_FOUND_BIT]       = found_q;
    out_data_d[swts_pkg::OUT_OVF_BIT]         = ovf_new;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;

endmodule

FILE: rtl/swts_checker.sv
// ----------------------------------------------------------------------------
// swts_checker
// Port-level checks on the shortest-window block, bound to the top level.
// ----------------------------------------------------------------------------
module swts_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [swts_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int PW2 = 2 * swts_pkg::POS_OUT_W;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // No run reported before one is found
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[swts_pkg::OUT_FOUND_BIT]
      |-> m_axis_tdata_o[PW2-1:0] == '0)
    else $error("best run nonzero without a match");

  // One request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in progress");

endmodule

bind shortest_window_with_target_sum swts_checker u_swts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
